@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the block's top-level module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTSB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PTSB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ptsb_pkg.sv @@
// ----------------------------------------------------------------------------
// ptsb_pkg
// Shared types and constants for the tone, sharpen and blend pixel block
// ----------------------------------------------------------------------------
package ptsb_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FRAC_BITS_DEF = 8;
  localparam int PADDR_W       = 5;

  localparam int GAIN_RST   = 256;
  localparam int WEIGHT_RST = 256;
  localparam int FW_RST     = 640;
  localparam int FH_RST     = 480;

  localparam logic [2:0] REG_GAIN   = 3'd0;
  localparam logic [2:0] REG_BRIGHT = 3'd1;
  localparam logic [2:0] REG_SHARP  = 3'd2;
  localparam logic [2:0] REG_INVERT = 3'd3;
  localparam logic [2:0] REG_WEIGHT = 3'd4;
  localparam logic [2:0] REG_WIDTH  = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHARP,
    S_BLEND,
    S_OUT
  } state_t;

  typedef struct packed {
    logic k1;
    logic emit;
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
    logic eof;
  } step_t;

  typedef struct packed {
    logic [7:0] ctr;
    logic [7:0] up;
    logic [7:0] dn;
    logic [7:0] lf;
    logic [7:0] rt;
    logic [7:0] orig;
  } win_t;

  typedef struct packed {
    logic sharp_en;
    logic invert;
    logic blend_en;
  } lane_ctl_t;

endpackage

@@ hw/rtl/ptsb_in_if.sv @@
// ----------------------------------------------------------------------------
// ptsb_in_if
// Pixel input channel: valid, ready and one pixel or drain beat
// ----------------------------------------------------------------------------
interface ptsb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_ch0;
  logic [7:0] in_ch1;
  logic [7:0] in_ch2;

  modport source (output valid, op, in_ch0, in_ch1, in_ch2, input ready);
  modport sink (input valid, op, in_ch0, in_ch1, in_ch2, output ready);
endinterface

@@ hw/rtl/ptsb_out_if.sv @@
// ----------------------------------------------------------------------------
// ptsb_out_if
// Result channel: valid, ready and one processed pixel beat
// ----------------------------------------------------------------------------
interface ptsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch0;
  logic [7:0] out_ch1;
  logic [7:0] out_ch2;
  logic       end_of_row;
  logic       end_of_frame;

  modport source (output valid, out_ch0, out_ch1, out_ch2, end_of_row, end_of_frame,
                  input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, end_of_row, end_of_frame,
                output ready);
endinterface

@@ hw/rtl/ptsb_line_buf.sv @@
// ----------------------------------------------------------------------------
// ptsb_line_buf
// Two toned line stores and the original pixel delay line
// ----------------------------------------------------------------------------
module ptsb_line_buf #(
  parameter int DEPTH = ptsb_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] ctr_addr,
  input  logic [$clog2(DEPTH)-1:0] rt_addr,
  input  logic [$clog2(DEPTH)-1:0] lf_addr,
  input  logic [23:0]              wr_upper,
  input  logic [23:0]              wr_lower,
  input  logic [23:0]              wr_orig,
  output logic [23:0]              up_q,
  output logic [23:0]              lf_q,
  output logic [23:0]              ctr_q,
  output logic [23:0]              rt_q,
  output logic [23:0]              orig_q
);
  import ptsb_pkg::*;

  logic [23:0] upper_mem [DEPTH];
  logic [23:0] lower_mem [DEPTH];
  logic [23:0] orig_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[ctr_addr] <= wr_upper;
      lower_mem[ctr_addr] <= wr_lower;
      orig_mem[ctr_addr]  <= wr_orig;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q   <= upper_mem[ctr_addr];
      lf_q   <= upper_mem[lf_addr];
      ctr_q  <= lower_mem[ctr_addr];
      rt_q   <= lower_mem[rt_addr];
      orig_q <= orig_mem[ctr_addr];
    end
  end

endmodule

@@ hw/rtl/ptsb_tone_lane.sv @@
// ----------------------------------------------------------------------------
// ptsb_tone_lane
// One channel of gain and offset with rounding and clamping
// ----------------------------------------------------------------------------
module ptsb_tone_lane #(
  parameter int FRAC_BITS = ptsb_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        x,
  input  logic [11:0]       gain,
  input  logic signed [8:0] offset,
  output logic [7:0]        tone_q
);
  import ptsb_pkg::*;

  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int TW   = (((10 + FRAC_BITS) > 21) ? (10 + FRAC_BITS) : 21) + 1;

  logic [19:0]             prod;
  logic [TW-1:0]           v;
  logic [TW-2-FRAC_BITS:0] hi;

  assign prod = 20'(x) * 20'(gain);
  assign v    = TW'(prod) + (TW'(offset) << FRAC_BITS) + TW'(HALF);
  assign hi   = v[TW-2:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (v[TW-1]) begin
        tone_q <= 8'd0;
      end else if (hi > 255) begin
        tone_q <= 8'd255;
      end else begin
        tone_q <= hi[7:0];
      end
    end
  end

endmodule

@@ hw/rtl/ptsb_finish_lane.sv @@
// ----------------------------------------------------------------------------
// ptsb_finish_lane
// One channel of laplacian sharpen, inversion and blend with the original
// ----------------------------------------------------------------------------
module ptsb_finish_lane #(
  parameter int FRAC_BITS = ptsb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en1,
  input  logic                 en2,
  input  ptsb_pkg::win_t       win,
  input  logic [11:0]          s,
  input  logic [FRAC_BITS:0]   w,
  input  ptsb_pkg::lane_ctl_t  ctl,
  output logic [7:0]           res
);
  import ptsb_pkg::*;

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int WL   = FRAC_BITS + 1;
  localparam int KW   = ((FRAC_BITS > 14) ? FRAC_BITS : 14) + 1;
  localparam int PW   = 8 + KW;
  localparam int DW   = ((PW > 22) ? PW : 22) + 2;
  localparam int BW   = FRAC_BITS + 10;
  localparam int XW   = FRAC_BITS + 9;

  logic [KW-1:0]           kc;
  logic [9:0]              nb;
  logic [PW-1:0]           p1_r;
  logic [21:0]             p2_r;
  logic [7:0]              ctr_r;
  logic [7:0]              orig_r;
  logic [DW-1:0]           v;
  logic [DW-2-FRAC_BITS:0] hi;
  logic [7:0]              rc;
  logic [7:0]              ts;
  logic [7:0]              ti;
  logic [WL-1:0]           wc;
  logic [XW-1:0]           bx_r;
  logic [XW-1:0]           bt_r;
  logic [7:0]              t2_r;
  logic                    bl_r;
  logic [BW-1:0]           sum;

  assign kc = KW'(ONE) + KW'({s, 2'b00});
  assign nb = 10'(win.up) + 10'(win.dn) + 10'(win.lf) + 10'(win.rt);

  // stage 1: centre gain and neighbour products
  always_ff @(posedge clk) begin
    if (en1) begin
      p1_r   <= PW'(win.ctr) * PW'(kc);
      p2_r   <= 22'(s) * 22'(nb);
      ctr_r  <= win.ctr;
      orig_r <= win.orig;
    end
  end

  assign v  = DW'(p1_r) - DW'(p2_r) + DW'(HALF);
  assign hi = v[DW-2:FRAC_BITS];
  assign rc = v[DW-1] ? 8'd0 : ((hi > 255) ? 8'd255 : hi[7:0]);
  assign ts = ctl.sharp_en ? rc : ctr_r;
  assign ti = ctl.invert ? ~ts : ts;
  assign wc = WL'(ONE) - w;

  // stage 2: blend products
  always_ff @(posedge clk) begin
    if (en2) begin
      bx_r <= XW'(orig_r) * XW'(wc);
      bt_r <= XW'(ti) * XW'(w);
      t2_r <= ti;
      bl_r <= ctl.blend_en;
    end
  end

  assign sum = BW'(bx_r) + BW'(bt_r) + BW'(HALF);
  assign res = bl_r ? sum[FRAC_BITS+7:FRAC_BITS] : t2_r;

endmodule

@@ hw/rtl/pixel_tone_sharpen_blend.sv @@
// ----------------------------------------------------------------------------
// pixel_tone_sharpen_blend
// Tone mapping, 3x3 laplacian sharpen and blend over a raster pixel stream
// ----------------------------------------------------------------------------
// Pixels enter row by row on in_chan (op 0) and processed pixels leave on
// out_chan; drain beats (op 1) after the last pixel of a frame push out the
// tail, one result per drain beat, frame_width plus one of them in all.
// A result appears one line plus one pixel after the pixel it belongs to.
// Per beat the sequencer walks read, sharpen, blend and output states; a
// beat with a result passes through all four and is loaded into the output
// register before the next beat is accepted, a beat with no result returns
// to idle after sharpen and a beat outside the frame is dropped in idle.
// The result sits in an output register, so a new beat is taken while the
// receiver stalls; the block waits in its output cycle only when a second
// result is ready before the first has gone.
// Registers are to be written over the APB port only while idle; the block
// does not enforce this. Frame size is latched at the first pixel of each
// frame. Reset returns the configuration registers to defaults and the
// position to the start of a frame; line stores need no clearing.
// ----------------------------------------------------------------------------
module pixel_tone_sharpen_blend #(
  parameter int MAX_WIDTH = ptsb_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = ptsb_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ptsb_in_if.sink                      in_chan,
  ptsb_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptsb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ptsb_pkg::*;

`include "assert_macros.svh"

  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int WCW      = $clog2(MAX_WIDTH + 1);
  localparam int CW       = (WCW > 11) ? WCW : 11;
  localparam int ONE      = 1 << FRAC_BITS;
  localparam int GMIN_LIM = (ONE - 1) / 10;
  localparam int GMIN     = (ONE + 9) / 10;
  localparam int SH_LIM   = ONE / 100;
  localparam int BL_LIM   = (99 * ONE - 1) / 100;
  localparam int WSW      = ((FRAC_BITS + 1) > 9) ? (FRAC_BITS + 1) : 9;
  localparam int RST_W    = (FW_RST > MAX_WIDTH) ? MAX_WIDTH : FW_RST;

  // configuration registers
  logic [11:0]       gain_r;
  logic signed [8:0] bright_r;
  logic [11:0]       sharp_r;
  logic              inv_r;
  logic [8:0]        weight_r;
  logic [10:0]       fw_r;
  logic [11:0]       fh_r;

  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= 12'(GAIN_RST);
      bright_r <= '0;
      sharp_r  <= '0;
      inv_r    <= 1'b0;
      weight_r <= 9'(WEIGHT_RST);
      fw_r     <= 11'(FW_RST);
      fh_r     <= 12'(FH_RST);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_GAIN:   gain_r   <= pwdata[11:0];
        REG_BRIGHT: bright_r <= pwdata[8:0];
        REG_SHARP:  sharp_r  <= pwdata[11:0];
        REG_INVERT: inv_r    <= pwdata[0];
        REG_WEIGHT: weight_r <= pwdata[8:0];
        REG_WIDTH:  fw_r     <= pwdata[10:0];
        REG_HEIGHT: fh_r     <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_GAIN:   prdata[11:0] = gain_r;
      REG_BRIGHT: prdata[8:0]  = bright_r;
      REG_SHARP:  prdata[11:0] = sharp_r;
      REG_INVERT: prdata[0]    = inv_r;
      REG_WEIGHT: prdata[8:0]  = weight_r;
      REG_WIDTH:  prdata[10:0] = fw_r;
      REG_HEIGHT: prdata[11:0] = fh_r;
      default:    prdata       = '0;
    endcase
  end

  // derived settings
  logic [CW-1:0]      fw_ext;
  logic [WCW-1:0]     eff_w;
  logic [11:0]        eff_h;
  logic [11:0]        gain_eff;
  logic [WSW-1:0]     w_ext;
  logic [WSW-1:0]     w_sat;
  lane_ctl_t          ctl;

  assign fw_ext   = CW'(fw_r);
  assign eff_w    = (fw_ext < CW'(2)) ? WCW'(2) :
                    (fw_ext > CW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(fw_ext);
  assign eff_h    = (fh_r < 12'd2) ? 12'd2 : fh_r;
  assign gain_eff = (gain_r <= 12'(GMIN_LIM)) ? 12'(GMIN) : gain_r;
  assign w_ext    = WSW'(weight_r);
  assign w_sat    = (w_ext > WSW'(ONE)) ? WSW'(ONE) : w_ext;

  assign ctl.sharp_en = sharp_r > 12'(SH_LIM);
  assign ctl.invert   = inv_r;
  assign ctl.blend_en = w_sat <= WSW'(BL_LIM);

  // frame position and step decode
  state_t          state_r, state_nxt;
  logic [AW-1:0]   col_r;
  logic [12:0]     row_r;
  logic [WCW-1:0]  lat_w_r;
  logic [11:0]     lat_h_r;

  logic            in_fire;
  logic            latch;
  logic [WCW-1:0]  cur_w;
  logic [11:0]     cur_h;
  logic            skip;
  logic [WCW-1:0]  w_m1;
  logic [AW-1:0]   ec_c;
  logic [12:0]     er_c;
  logic [WCW-1:0]  col_inc;
  step_t           step_c;

  assign in_fire = in_chan.valid && (state_r == S_IDLE);
  assign latch   = (col_r == '0) && (row_r == '0) && !in_chan.op;
  assign cur_w   = latch ? eff_w : lat_w_r;
  assign cur_h   = latch ? eff_h : lat_h_r;
  assign skip    = in_chan.op ? (row_r < 13'(cur_h)) : (row_r >= 13'(cur_h));
  assign w_m1    = cur_w - WCW'(1);
  assign ec_c    = (col_r != '0) ? col_r - AW'(1) : w_m1[AW-1:0];
  assign er_c    = (col_r != '0) ? row_r - 13'd1 : row_r - 13'd2;
  assign col_inc = WCW'(col_r) + WCW'(1);

  assign step_c.k1        = (col_r != '0) || (row_r != '0);
  assign step_c.emit      = (row_r >= 13'd2) || ((row_r == 13'd1) && (col_r != '0));
  assign step_c.first_row = er_c == '0;
  assign step_c.last_row  = er_c == 13'(cur_h) - 13'd1;
  assign step_c.first_col = ec_c == '0;
  assign step_c.last_col  = WCW'(ec_c) == w_m1;
  assign step_c.eof       = step_c.emit && step_c.last_col && step_c.last_row;

  step_t           step_r;
  logic [AW-1:0]   ec_r;
  logic            op_r;
  logic [23:0]     x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      lat_w_r <= WCW'(RST_W);
      lat_h_r <= 12'(FH_RST);
    end else if (in_fire && !skip) begin
      if (latch) begin
        lat_w_r <= eff_w;
        lat_h_r <= eff_h;
      end
      if (step_c.eof) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_inc >= cur_w) begin
        col_r <= '0;
        row_r <= row_r + 13'd1;
      end else begin
        col_r <= col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !skip) begin
      step_r <= step_c;
      ec_r   <= ec_c;
      op_r   <= in_chan.op;
      x_r    <= {in_chan.in_ch2, in_chan.in_ch1, in_chan.in_ch0};
    end
  end

  // sequencer
  logic out_valid_r;
  logic rd_en, tone_en, sh_en, bl_en, out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    tone_en   = 1'b0;
    sh_en     = 1'b0;
    bl_en     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid && !skip) state_nxt = S_READ;
      end
      S_READ: begin
        rd_en     = 1'b1;
        tone_en   = 1'b1;
        state_nxt = S_SHARP;
      end
      S_SHARP: begin
        sh_en     = 1'b1;
        state_nxt = step_r.emit ? S_BLEND : S_IDLE;
      end
      S_BLEND: begin
        bl_en     = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_chan.ready = state_r == S_IDLE;

  // tone lanes
  logic [23:0] tone;

  for (genvar i = 0; i < 3; i++) begin : g_tone
    ptsb_tone_lane #(.FRAC_BITS(FRAC_BITS)) u_tone (
      .clk    (clk),
      .en     (tone_en),
      .x      (x_r[8*i +: 8]),
      .gain   (gain_eff),
      .offset (bright_r),
      .tone_q (tone[8*i +: 8])
    );
  end

  // line stores and pending pixel
  logic [23:0] pend_r;
  logic [23:0] orig_pend_r;
  logic [23:0] up_q, lf_q, ctr_q, rt_q, orig_q;

  ptsb_line_buf #(.DEPTH(MAX_WIDTH)) u_line_buf (
    .clk      (clk),
    .rd_en    (rd_en),
    .wr_en    (sh_en && step_r.k1),
    .ctr_addr (ec_r),
    .rt_addr  (ec_r + AW'(1)),
    .lf_addr  (ec_r - AW'(1)),
    .wr_upper (ctr_q),
    .wr_lower (pend_r),
    .wr_orig  (orig_pend_r),
    .up_q     (up_q),
    .lf_q     (lf_q),
    .ctr_q    (ctr_q),
    .rt_q     (rt_q),
    .orig_q   (orig_q)
  );

  always_ff @(posedge clk) begin
    if (sh_en && !step_r.eof) begin
      pend_r      <= op_r ? 24'd0 : tone;
      orig_pend_r <= op_r ? 24'd0 : x_r;
    end
  end

  // window with reflected borders
  logic [23:0] up_px, dn_px, lf_px, rt_px, rt0_px;

  assign up_px  = step_r.first_row ? pend_r : up_q;
  assign dn_px  = step_r.last_row ? up_px : pend_r;
  assign rt0_px = step_r.last_col ? 24'd0 : rt_q;
  assign lf_px  = step_r.first_col ? rt0_px : lf_q;
  assign rt_px  = step_r.last_col ? lf_px : rt0_px;

  // finishing lanes
  logic [23:0] res;

  for (genvar i = 0; i < 3; i++) begin : g_finish
    win_t win;

    assign win.ctr  = ctr_q[8*i +: 8];
    assign win.up   = up_px[8*i +: 8];
    assign win.dn   = dn_px[8*i +: 8];
    assign win.lf   = lf_px[8*i +: 8];
    assign win.rt   = rt_px[8*i +: 8];
    assign win.orig = orig_q[8*i +: 8];

    ptsb_finish_lane #(.FRAC_BITS(FRAC_BITS)) u_finish (
      .clk (clk),
      .en1 (sh_en),
      .en2 (bl_en),
      .win (win),
      .s   (sharp_r),
      .w   (w_sat[FRAC_BITS:0]),
      .ctl (ctl),
      .res (res[8*i +: 8])
    );
  end

  // merged output register
  logic [23:0] out_px_r;
  logic        out_eor_r;
  logic        out_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_px_r  <= res;
      out_eor_r <= step_r.last_col;
      out_eof_r <= step_r.eof;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_ch0      = out_px_r[7:0];
  assign out_chan.out_ch1      = out_px_r[15:8];
  assign out_chan.out_ch2      = out_px_r[23:16];
  assign out_chan.end_of_row   = out_eor_r;
  assign out_chan.end_of_frame = out_eof_r;

  `PTSB_ASSERT_NXT(a_fire_to_read, clk, rst_n, in_fire && !skip, state_r == S_READ)
  `PTSB_ASSERT_IMP(a_load_from_out, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_OUT)
  `PTSB_ASSERT_IMP(a_col_in_frame, clk, rst_n, state_r == S_IDLE, WCW'(col_r) < lat_w_r)

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tone, sharpen and blend pixel block
// ----------------------------------------------------------------------------
// Whole frames of random pixels are streamed in under many register settings,
// each followed by its drain beats. Stray beats that the block should ignore
// are mixed in. Both channels idle at random. Every result is checked
// against an in-bench model of the line stores and the per-channel
// arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptsb_pkg::*;

  typedef struct {
    logic       op;
    logic [7:0] c0, c1, c2;
    bit         hold;
  } beat_t;

  typedef struct packed {
    logic [7:0] c0, c1, c2;
    logic       eor, eof;
  } pix_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam int   MW       = MAX_WIDTH_DEF;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  ptsb_in_if  in_if ();
  ptsb_out_if out_if ();

  pixel_tone_sharpen_blend dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register mirror
  logic [11:0] m_gain, m_sharp, m_fh;
  logic [8:0]  m_off, m_wt;
  logic        m_inv;
  logic [10:0] m_fw;

  // frame model state
  logic [23:0] upper_row [MW];
  logic [23:0] lower_row [MW];
  logic [23:0] orig_row [MW+1];
  logic [23:0] win [9];
  int unsigned col_pos, row_pos, lat_w, lat_h;

  beat_t pending[$];
  pix_t  pix_due[$];
  int    gap_left, stall_left, errors, n_pix, n_drain, n_results, n_phases;
  bit    burst;
  beat_t cur;
  pix_t  got, want;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0; in_if.op = OP_PIXEL;
    in_if.in_ch0 = '0; in_if.in_ch1 = '0; in_if.in_ch2 = '0;
    out_if.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int unsigned width_eff();
    if (m_fw < 2) return 2;
    if (m_fw > MW) return MW;
    return m_fw;
  endfunction

  function automatic int unsigned height_eff();
    return (m_fh < 2) ? 2 : m_fh;
  endfunction

  function automatic logic [7:0] round_clamp(longint v);
    v += 128;
    if (v < 0) return 8'd0;
    v = v / 256;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [23:0] tone(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    longint g, off;
    logic [7:0] x [3];
    logic [23:0] r;
    g = m_gain;
    if (g * 10 < 256) g = 26;
    off = $signed(m_off);
    x[0] = a; x[1] = b; x[2] = c;
    for (int i = 0; i < 3; i++) r[8*i +: 8] = round_clamp(x[i] * g + off * 256);
    return r;
  endfunction

  function automatic logic [7:0] finish_lane(int i, logic [23:0] orig);
    longint s, w, nb, v;
    logic [7:0] t;
    s = m_sharp;
    w = m_wt;
    t = win[4][8*i +: 8];
    if (s * 100 > 256) begin
      nb = win[1][8*i +: 8] + win[7][8*i +: 8] + win[3][8*i +: 8] + win[5][8*i +: 8];
      t = round_clamp(longint'(t) * (256 + 4 * s) - s * nb);
    end
    if (m_inv) t = 8'd255 - t;
    if (w > 256) w = 256;
    if (w * 100 < 99 * 256) begin
      v = longint'(orig[8*i +: 8]) * (256 - w) + longint'(t) * w + 128;
      t = v[15:8];
    end
    return t;
  endfunction

  // advance the frame model by one accepted beat, queueing any result
  function automatic void model_beat(beat_t b);
    longint k, total;
    int unsigned ec, er;
    logic [23:0] up, dn, lf, rt, npx, norig;
    bit eof;
    pix_t p;
    if (col_pos == 0 && row_pos == 0 && b.op == OP_PIXEL) begin
      lat_w = width_eff();
      lat_h = height_eff();
    end
    k = longint'(row_pos) * lat_w + col_pos;
    total = longint'(lat_w) * lat_h;
    if ((b.op == OP_DRAIN) ? (k < total) : (k >= total)) return;
    npx = '0; norig = '0;
    if (b.op == OP_PIXEL) begin
      npx = tone(b.c0, b.c1, b.c2);
      norig = {b.c2, b.c1, b.c0};
    end
    eof = 0;
    if (k >= 1) begin
      ec = col_pos ? col_pos - 1 : lat_w - 1;
      if (k >= lat_w + 1) begin
        er = col_pos ? row_pos - 1 : row_pos - 2;
        dn = win[8];
        up = (er > 0) ? upper_row[ec] : dn;
        if (er >= lat_h - 1) dn = up;
        rt = (ec + 1 < lat_w) ? lower_row[ec + 1] : '0;
        lf = (ec > 0) ? upper_row[ec - 1] : rt;
        if (ec + 1 >= lat_w) rt = lf;
        win[1] = up; win[7] = dn; win[3] = lf; win[5] = rt;
        win[4] = lower_row[ec];
        p.c0 = finish_lane(0, orig_row[ec]);
        p.c1 = finish_lane(1, orig_row[ec]);
        p.c2 = finish_lane(2, orig_row[ec]);
        p.eor = (ec == lat_w - 1);
        eof = (ec == lat_w - 1) && (er == lat_h - 1);
        p.eof = eof;
        pix_due.push_back(p);
      end
      upper_row[ec] = lower_row[ec];
      lower_row[ec] = win[8];
      orig_row[ec] = orig_row[MW];
      if (eof) begin
        col_pos = 0;
        row_pos = 0;
        return;
      end
    end
    win[8] = npx;
    orig_row[MW] = norig;
    col_pos++;
    if (col_pos >= lat_w) begin
      col_pos = 0;
      row_pos++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending.size() > 0 &&
                   !(pending[0].hold && (in_if.valid || pix_due.size() != 0))) begin
        cur = pending.pop_front();
        in_if.op <= cur.op;
        in_if.in_ch0 <= cur.c0;
        in_if.in_ch1 <= cur.c1;
        in_if.in_ch2 <= cur.c2;
        in_if.valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_if.ready <= (stall_left == 0);
    end
  end

  // beat monitors and checker
  always @(posedge clk) begin
    beat_t b;
    if (rst_n && in_if.valid && in_if.ready) begin
      b.op = in_if.op; b.c0 = in_if.in_ch0; b.c1 = in_if.in_ch1; b.c2 = in_if.in_ch2;
      b.hold = 0;
      model_beat(b);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      got.c0 = out_if.out_ch0; got.c1 = out_if.out_ch1; got.c2 = out_if.out_ch2;
      got.eor = out_if.end_of_row; got.eof = out_if.end_of_frame;
      n_results++;
      if (pix_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h %h %h", got.c0, got.c1, got.c2);
      end else begin
        want = pix_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected %h %h %h eor %b eof %b, got %h %h %h eor %b eof %b",
                     n_results, want.c0, want.c1, want.c2, want.eor, want.eof,
                     got.c0, got.c1, got.c2, got.eor, got.eof);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(idx * 4); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GAIN:   m_gain = val[11:0];
      REG_BRIGHT: m_off = val[8:0];
      REG_SHARP:  m_sharp = val[11:0];
      REG_INVERT: m_inv = val[0];
      REG_WEIGHT: m_wt = val[8:0];
      REG_WIDTH:  m_fw = val[10:0];
      REG_HEIGHT: m_fh = val[11:0];
      default: ;
    endcase
  endtask

  task automatic push_beat(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c, bit hold);
    beat_t t;
    t.op = op; t.c0 = a; t.c1 = b; t.c2 = c; t.hold = hold;
    pending.push_back(t);
    if (op == OP_PIXEL) n_pix++;
    else n_drain++;
  endtask

  function automatic logic [7:0] pick_chan(int style);
    if (style == 1) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    if (style == 2) return 8'($urandom_range(100, 140));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_frame(bit noise, bit hold);
    int w, h, style;
    w = width_eff();
    h = height_eff();
    style = $urandom_range(0, 3);
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 29) == 0) push_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00, 0);
      push_beat(OP_PIXEL, pick_chan(style), pick_chan(style), pick_chan(style), hold && i == 0);
    end
    if (noise && $urandom_range(0, 3) == 0)
      push_beat(OP_PIXEL, pick_chan(0), pick_chan(0), pick_chan(0), 0);
    for (int i = 0; i <= w; i++) push_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00, 0);
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_if.valid || pix_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(int g, int o, int s, int inv, int wt, int fw, int fh,
                           int frames, bit noise, bit hold);
    write_reg(REG_GAIN, g);
    write_reg(REG_BRIGHT, o);
    write_reg(REG_SHARP, s);
    write_reg(REG_INVERT, inv);
    write_reg(REG_WEIGHT, wt);
    write_reg(REG_WIDTH, fw);
    write_reg(REG_HEIGHT, fh);
    burst = ($urandom_range(0, 4) == 0);
    for (int f = 0; f < frames; f++) push_frame(noise, hold);
    settle();
    n_phases++;
  endtask

  initial begin
    int pick_s, stop_at;
    m_gain = 12'(GAIN_RST); m_off = '0; m_sharp = '0; m_inv = 0; m_wt = 9'(WEIGHT_RST);
    m_fw = 11'(FW_RST); m_fh = 12'(FH_RST);
    col_pos = 0; row_pos = 0; lat_w = FW_RST; lat_h = FH_RST;
    foreach (win[i]) win[i] = '0;
    errors = 0; n_pix = 0; n_drain = 0; n_results = 0; n_phases = 0; burst = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed: extreme and threshold values of several registers and stray beats
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    push_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00, 0);
    push_beat(OP_PIXEL, 8'h00, 8'hff, 8'h00, 0);
    push_beat(OP_PIXEL, 8'hff, 8'h00, 8'hff, 0);
    push_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00, 0);
    push_beat(OP_PIXEL, 8'h80, 8'h7f, 8'h01, 0);
    push_beat(OP_PIXEL, 8'hfe, 8'h00, 8'hff, 0);
    push_beat(OP_PIXEL, 8'h00, 8'hff, 8'h55, 0);
    push_beat(OP_PIXEL, 8'hff, 8'haa, 8'h00, 0);
    push_beat(OP_PIXEL, 8'h12, 8'h34, 8'h56, 0);
    for (int i = 0; i < 4; i++) push_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00, 0);
    settle();
    run_phase(4095, 255, 4095, 1, 0, 2, 2, 1, 0, 1);
    run_phase(0, 9'h101, 3, 0, 511, 0, 1, 1, 0, 0);
    run_phase(25, -1, 2, 1, 253, 1, 0, 1, 0, 0);
    run_phase(26, 0, 256, 0, 254, 48, 2, 1, 0, 0);
    run_phase(300, 10, 40, 0, 128, 2, 40, 1, 0, 0);
    run_phase(256, 0, 0, 0, 256, 32, 3, 1, 1, 0);

    // random settings, all on small frames
    stop_at = 900;
    while (n_pix + n_drain < stop_at) begin
      case ($urandom_range(0, 3))
        0: pick_s = 0;
        1: pick_s = $urandom_range(1, 4);
        default: pick_s = $urandom_range(0, 4095);
      endcase
      run_phase($urandom_range(0, 4095), $urandom_range(0, 511), pick_s,
                $urandom_range(0, 1),
                $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(250, 260),
                $urandom_range(2, 8), $urandom_range(2, 6), $urandom_range(1, 3), 1,
                $urandom_range(0, 3) == 0);
    end

    if (pix_due.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", pix_due.size());
    end
    $display("covered %0d pixel beats and %0d drain beats over %0d register settings",
             n_pix, n_drain, n_phases);
    $display("%0d results checked, %0d mismatches", n_results, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ptsb_pkg.sv
hw/rtl/ptsb_in_if.sv
hw/rtl/ptsb_out_if.sv
hw/rtl/ptsb_line_buf.sv
hw/rtl/ptsb_tone_lane.sv
hw/rtl/ptsb_finish_lane.sv
hw/rtl/pixel_tone_sharpen_blend.sv
verif/testbench.sv
